// ----- hw/rtl/mwtg_pkg.sv -----
package mwtg_pkg;

    // Fixed widths of the sample path.
    localparam int PHASE_W  = 32;
    localparam int GAIN_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int AMP_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Peak amplitude of every waveform before the gain is applied.
    localparam int AMPLITUDE = 24000;
    localparam logic signed [AMP_W-1:0] AMP_Q16 = AMP_W'(AMPLITUDE * 65536);

    // Quarter-wave sine table.
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_IDX_W = $clog2(SINE_TABLE_DEPTH);
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210};

    // Reset values of the configuration registers.
    localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 32'd85704563;
    localparam logic [GAIN_W-1:0]  GAIN_RESET       = 16'd2048;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_SAWTOOTH = 2'd3
    } t_waveform;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAVEFORM      = 2'd0,
        CFG_PHASE_STEP    = 2'd1,
        CFG_COMBINED_GAIN = 2'd2
    } t_cfg_reg;

    typedef logic [SINE_TABLE_DEPTH-1:0][15:0] t_sine_table;

    // Phase stage payload: the phase used for this sample and its burst flag.
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               last;
    } t_phase_stage;

    // Shape stage payload: the wave value scaled to 24000 in Q.16.
    typedef struct packed {
        logic signed [AMP_W-1:0] amp;
        logic                    last;
    } t_amp_stage;

    // Entry i holds round(24000 * sin(pi/2 * (i + 0.5) / depth)), found with a
    // Q30 Taylor series whose products are truncated. Evaluated at elaboration.
    function automatic t_sine_table build_sine_table();
        t_sine_table        tbl;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        rnd;
        logic signed [63:0] sum;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            x    = (HALF_PI_Q30 * 64'(2 * i + 1)) / 64'(2 * SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = signed'(x);
            for (int k = 0; k < 7; k++) begin
                term = (term * x2) >> 30;
                term = term / TAYLOR_DIV[k];
                if (k[0] == 1'b0) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0) begin
                sum = '0;
            end
            rnd    = (64'(sum) * 64'(AMPLITUDE) + (64'd1 << 29)) >> 30;
            tbl[i] = rnd[15:0];
        end
        return tbl;
    endfunction

endpackage

// ----- hw/rtl/mwtg_ifs.sv -----
interface mwtg_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface mwtg_sample_if;
    import mwtg_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface mwtg_cfg_if;
    import mwtg_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/multi_waveform_tone_generator.sv -----
// Direct digital synthesis tone source. Every tick transaction yields one
// signed 16-bit sample: a 32-bit phase accumulator advancing by phase_step
// per sample is shaped into a sine (quarter-wave table of 256 entries,
// built at elaboration), square, triangle or sawtooth wave of peak 24000,
// scaled by the unsigned Q4.12 combined gain, truncated toward zero and
// saturated. Setting restart on a tick zeroes the phase and the burst
// counter before that sample is made. The last flag is high on every
// BURST_SAMPLES-th sample. The path is three register stages (phase,
// shape, gain), and a sample leaves from the gain stage's output
// register. One tick is taken every cycle as long as the sample side
// keeps up; each stage holds its item on its own, so bubbles close up
// under a stall. Configuration writes are always taken and must only
// be issued while no sample is in flight; an unknown index is ignored.
module multi_waveform_tone_generator #(
    parameter int BURST_SAMPLES = 4096
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    mwtg_tick_if.sink     i_tick,
    mwtg_cfg_if.sink      i_cfg,
    mwtg_sample_if.source o_sample
);
    import mwtg_pkg::*;

    // Configuration registers.
    t_waveform          r_waveform;
    logic [PHASE_W-1:0] r_phase_step;
    logic [GAIN_W-1:0]  r_gain;

    // Stage handshakes and payloads.
    logic         phase_valid;
    logic         shape_ready;
    t_phase_stage phase_stage;
    logic         shape_valid;
    logic         gain_ready;
    t_amp_stage   amp_stage;
    logic         tick_ready;
    logic         out_valid;
    logic signed [SAMPLE_W-1:0] out_sample;
    logic         out_last;

    // The configuration port never stalls.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform   <= WAVE_SINE;
            r_phase_step <= PHASE_STEP_RESET;
            r_gain       <= GAIN_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_WAVEFORM:      r_waveform   <= t_waveform'(i_cfg.data[1:0]);
                CFG_PHASE_STEP:    r_phase_step <= i_cfg.data[PHASE_W-1:0];
                CFG_COMBINED_GAIN: r_gain       <= i_cfg.data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Phase accumulator and burst counter; the phase used for this sample
    // is registered here.
    mwtg_phase #(
        .BURST_SAMPLES (BURST_SAMPLES)
    ) u_phase (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_tick.valid),
        .i_restart    (i_tick.restart),
        .i_phase_step (r_phase_step),
        .o_ready      (tick_ready),
        .o_valid      (phase_valid),
        .o_stage      (phase_stage),
        .i_ready      (shape_ready)
    );

    assign i_tick.ready = tick_ready;

    // Waveform shaping: table lookup, square level, or ramp times the peak amplitude.
    mwtg_shape u_shape (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_waveform (r_waveform),
        .i_valid    (phase_valid),
        .i_stage    (phase_stage),
        .o_ready    (shape_ready),
        .o_valid    (shape_valid),
        .o_stage    (amp_stage),
        .i_ready    (gain_ready)
    );

    // Gain multiply, truncation and saturation into the output register.
    mwtg_gain u_gain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_gain   (r_gain),
        .i_valid  (shape_valid),
        .i_stage  (amp_stage),
        .o_ready  (gain_ready),
        .o_valid  (out_valid),
        .o_sample (out_sample),
        .o_last   (out_last),
        .i_ready  (o_sample.ready)
    );

    assign o_sample.valid  = out_valid;
    assign o_sample.sample = out_sample;
    assign o_sample.last   = out_last;

endmodule

// ----- hw/rtl/mwtg_phase.sv -----
module mwtg_phase #(
    parameter int BURST_SAMPLES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_restart,
    input  logic [mwtg_pkg::PHASE_W-1:0]  i_phase_step,
    output logic                          o_ready,
    output logic                          o_valid,
    output mwtg_pkg::t_phase_stage        o_stage,
    input  logic                          i_ready
);
    import mwtg_pkg::*;

    localparam int CNT_W = $clog2(BURST_SAMPLES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BURST_SAMPLES - 1);

    logic [PHASE_W-1:0] r_acc;
    logic [PHASE_W-1:0] n_acc;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               r_valid;
    t_phase_stage       r_stage;
    t_phase_stage       n_stage;
    logic               take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    // A restart clears phase and count before this sample uses them.
    always_comb begin
        n_stage.phase = i_restart ? '0 : r_acc;
        n_stage.last  = (i_restart ? '0 : r_cnt) >= CNT_LAST;
        n_acc         = n_stage.phase + i_phase_step;
        n_cnt         = n_stage.last ? '0 : (i_restart ? CNT_W'(1) : r_cnt + CNT_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_acc <= n_acc;
                r_cnt <= n_cnt;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

// ----- hw/rtl/mwtg_shape.sv -----
module mwtg_shape (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mwtg_pkg::t_waveform    i_waveform,
    input  logic                   i_valid,
    input  mwtg_pkg::t_phase_stage i_stage,
    output logic                   o_ready,
    output logic                   o_valid,
    output mwtg_pkg::t_amp_stage   o_stage,
    input  logic                   i_ready
);
    import mwtg_pkg::*;

    localparam t_sine_table SINE_TABLE = build_sine_table();
    localparam logic signed [18:0] HALF_TURN  = 19'sd65536;
    localparam logic signed [18:0] THREE_HALF = 19'sd196608;

    logic                    r_valid;
    t_amp_stage              r_stage;
    t_amp_stage              n_stage;
    logic [15:0]             u;
    logic signed [18:0]      ramp;
    logic [SINE_IDX_W-1:0]   idx;
    logic signed [AMP_W-1:0] sine_mag;
    logic                    take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;
    assign u       = i_stage.phase[31:16];

    always_comb begin
        // Quarter-wave lookup: odd quadrants mirror, the upper half of the phase negates.
        idx = i_stage.phase[29 -: SINE_IDX_W];
        if (i_stage.phase[30]) begin
            idx = ~idx;
        end
        sine_mag = signed'({SINE_TABLE[idx], 16'h0000});

        if (i_waveform == WAVE_TRIANGLE) begin
            if (!i_stage.phase[31]) begin
                ramp = signed'({1'b0, u, 2'b00}) - HALF_TURN;
            end else begin
                ramp = THREE_HALF - signed'({1'b0, u, 2'b00});
            end
        end else begin
            ramp = signed'({2'b00, u, 1'b0}) - HALF_TURN;
        end

        n_stage.last = i_stage.last;
        case (i_waveform)
            WAVE_SQUARE:   n_stage.amp = i_stage.phase[31] ? -AMP_Q16 : AMP_Q16;
            WAVE_TRIANGLE,
            WAVE_SAWTOOTH: n_stage.amp = AMP_W'(ramp) * AMP_W'(AMPLITUDE);
            default:       n_stage.amp = i_stage.phase[31] ? -sine_mag : sine_mag;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

// ----- hw/rtl/mwtg_gain.sv -----
module mwtg_gain (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [mwtg_pkg::GAIN_W-1:0]         i_gain,
    input  logic                                i_valid,
    input  mwtg_pkg::t_amp_stage                i_stage,
    output logic                                o_ready,
    output logic                                o_valid,
    output logic signed [mwtg_pkg::SAMPLE_W-1:0] o_sample,
    output logic                                o_last,
    input  logic                                i_ready
);
    import mwtg_pkg::*;

    localparam int PROD_W = 48;

    logic                       r_valid;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [SAMPLE_W-1:0] n_sample;
    logic                       r_last;
    logic signed [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]          mag;
    logic [19:0]                whole;
    logic                       take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    // Q.16 wave times Q4.12 gain is Q.28; drop the fraction toward zero.
    always_comb begin
        prod  = PROD_W'(i_stage.amp) * PROD_W'(signed'({1'b0, i_gain}));
        mag   = prod[PROD_W-1] ? unsigned'(-prod) : unsigned'(prod);
        whole = mag[47:28];
        if (!prod[PROD_W-1]) begin
            n_sample = (whole > 20'd32767) ? 16'sh7FFF : signed'(whole[15:0]);
        end else begin
            n_sample = (whole > 20'd32768) ? 16'sh8000 : -signed'(whole[15:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_sample <= n_sample;
            r_last   <= i_stage.last;
        end
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;
    assign o_last   = r_last;

endmodule
